>>> sv/fcpm_pkg.sv
`timescale 1ns / 1ps

package fcpm_pkg;

	// pixel components and luma
	localparam int PIX_W  = 8;
	localparam int LUMA_W = 18;
	localparam logic [LUMA_W-1:0] LUMA_KR    = 18'd299;
	localparam logic [LUMA_W-1:0] LUMA_KG    = 18'd587;
	localparam logic [LUMA_W-1:0] LUMA_KB    = 18'd114;
	localparam logic [LUMA_W-1:0] LUMA_LIMIT = 18'd150000;

	// color rule bounds
	localparam logic [PIX_W-1:0] RED_MIN   = 8'd190;
	localparam logic [PIX_W-1:0] GREEN_MIN = 8'd100;
	localparam logic [PIX_W-1:0] BLUE_MAX  = 8'd140;

	// counters
	localparam int MAX_FRAME_PIXELS = 2097152;
	localparam int CNT_W = 22;
	localparam int CNT_SAT_MAX = 4194303;
	localparam logic [CNT_W-1:0] CNT_LIMIT =
		CNT_W'((MAX_FRAME_PIXELS < CNT_SAT_MAX) ? MAX_FRAME_PIXELS : CNT_SAT_MAX);

	// Q16 level and configuration
	localparam int LEVEL_W = 17;
	localparam int RATE_W  = 8;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;
	localparam logic [LEVEL_W-1:0] Q16_ONE = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_AREA_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE     = 2'd2;

	localparam logic [LEVEL_W-1:0] AREA_RESET = 17'd1311;
	localparam logic [LEVEL_W-1:0] FREQ_RESET = 17'd13107;
	localparam logic [RATE_W-1:0]  RATE_RESET = 8'd25;

	// level division
	localparam int NUM_W  = RATE_W + LEVEL_W;
	localparam int DIVR_W = RATE_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int PROD_W = LEVEL_W + CNT_W;

	// queue between classifier and accumulator
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic color;
		logic luma_hit;
		logic last;
	} class_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

>>> sv/fcpm_front.sv
`timescale 1ns / 1ps

module fcpm_front (
	input  logic [fcpm_pkg::PIX_W-1:0] red,
	input  logic [fcpm_pkg::PIX_W-1:0] green,
	input  logic [fcpm_pkg::PIX_W-1:0] blue,
	input  logic                       frame_end,
	output fcpm_pkg::class_t           cls
);

	logic [fcpm_pkg::LUMA_W-1:0] luma;

	assign luma = {10'b0, red}   * fcpm_pkg::LUMA_KR
	            + {10'b0, green} * fcpm_pkg::LUMA_KG
	            + {10'b0, blue}  * fcpm_pkg::LUMA_KB;

	always_comb begin
		cls.color = (red > green) && (green > blue) && (red > fcpm_pkg::RED_MIN)
		         && (green > fcpm_pkg::GREEN_MIN) && (blue < fcpm_pkg::BLUE_MAX);
		// level gate is applied later, in order with the level updates
		cls.luma_hit = luma > fcpm_pkg::LUMA_LIMIT;
		cls.last = frame_end;
	end

endmodule

>>> sv/fcpm_queue.sv
`timescale 1ns / 1ps

module fcpm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fcpm_pkg::class_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output fcpm_pkg::class_t pop_data
);

	fcpm_pkg::class_t             mem_q [fcpm_pkg::QUEUE_DEPTH];
	logic [fcpm_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [fcpm_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [fcpm_pkg::QPTR_W:0]    count_q;

	assign full      = count_q == (fcpm_pkg::QPTR_W + 1)'(fcpm_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (fcpm_pkg::QPTR_W + 1)'(fcpm_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

>>> sv/fcpm_back.sv
`timescale 1ns / 1ps

module fcpm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fcpm_pkg::cfg_wr_t              cfg,
	input  logic                           q_not_empty,
	input  fcpm_pkg::class_t               q_data,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           fire_mask,
	output logic                           by_color_rule,
	output logic                           frame_done,
	output logic [fcpm_pkg::CNT_W-1:0]     fire_count,
	output logic [fcpm_pkg::CNT_W-1:0]     color_rule_count,
	output logic                           color_enough,
	output logic [fcpm_pkg::LEVEL_W-1:0]   history_level
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	function automatic logic [fcpm_pkg::CNT_W-1:0] sat_inc(
		input logic [fcpm_pkg::CNT_W-1:0] v,
		input logic                       inc
	);
		if (!inc) begin
			return v;
		end
		return (v >= fcpm_pkg::CNT_LIMIT) ? fcpm_pkg::CNT_LIMIT : v + 1'b1;
	endfunction

	logic [2:0] state_q;

	logic [fcpm_pkg::LEVEL_W-1:0] area_q;
	logic [fcpm_pkg::LEVEL_W-1:0] freq_q;
	logic [fcpm_pkg::RATE_W-1:0]  rate_q;
	logic [fcpm_pkg::LEVEL_W-1:0] level_q;

	logic [fcpm_pkg::CNT_W-1:0] fire_tally_q;
	logic [fcpm_pkg::CNT_W-1:0] color_tally_q;
	logic [fcpm_pkg::CNT_W-1:0] pixel_tally_q;

	// frame-end work registers
	logic [fcpm_pkg::CNT_W-1:0]  fcnt_q;
	logic [fcpm_pkg::CNT_W-1:0]  ccnt_q;
	logic [fcpm_pkg::CNT_W-1:0]  pcnt_q;
	logic                        mask_q;
	logic                        color_q;
	logic                        enough_q;
	logic [fcpm_pkg::PROD_W-1:0] prod_q;
	logic [fcpm_pkg::NUM_W-1:0]  num_q;
	logic [fcpm_pkg::DIVR_W-1:0] divr_q;
	logic [fcpm_pkg::DIVR_W-1:0] rem_q;
	logic [fcpm_pkg::STEP_W-1:0] step_q;

	logic out_valid_q;
	logic out_free;

	logic                         fire;
	logic [fcpm_pkg::CNT_W-1:0]   fcnt;
	logic [fcpm_pkg::CNT_W-1:0]   ccnt;
	logic [fcpm_pkg::CNT_W-1:0]   pcnt;
	logic                         enough;
	logic [fcpm_pkg::NUM_W-1:0]   num;
	logic [fcpm_pkg::DIVR_W:0]    rem_sh;
	logic                         rem_ge;
	logic [fcpm_pkg::LEVEL_W-1:0] lvl;
	logic                         load_pix;
	logic                         load_frame;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign pop       = (state_q == ST_IDLE) && q_not_empty && out_free;
	assign load_pix  = pop && !q_data.last;
	assign load_frame = (state_q == ST_OUT) && out_free;

	always_comb begin
		fire = q_data.color || (q_data.luma_hit && (level_q < freq_q));
		fcnt = sat_inc(fire_tally_q, fire);
		ccnt = sat_inc(color_tally_q, q_data.color);
		pcnt = sat_inc(pixel_tally_q, 1'b1);

		enough = {1'b0, ccnt_q, 16'b0} > prod_q;
		num = fcpm_pkg::NUM_W'(level_q) * fcpm_pkg::NUM_W'(rate_q)
		    + (enough ? fcpm_pkg::NUM_W'(fcpm_pkg::Q16_ONE) : '0);

		rem_sh = {rem_q, num_q[fcpm_pkg::NUM_W-1]};
		rem_ge = rem_sh >= {1'b0, divr_q};

		// quotient sits in num_q once the division is through
		lvl = (num_q > fcpm_pkg::NUM_W'(fcpm_pkg::Q16_ONE)) ? fcpm_pkg::Q16_ONE
		    : num_q[fcpm_pkg::LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= fcpm_pkg::AREA_RESET;
			freq_q <= fcpm_pkg::FREQ_RESET;
			rate_q <= fcpm_pkg::RATE_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				fcpm_pkg::REG_AREA_THRESHOLD: area_q <= cfg.data;
				fcpm_pkg::REG_FREQ_THRESHOLD: freq_q <= cfg.data;
				fcpm_pkg::REG_FRAME_RATE:     rate_q <= cfg.data[fcpm_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			level_q       <= fcpm_pkg::Q16_ONE;
			fire_tally_q  <= '0;
			color_tally_q <= '0;
			pixel_tally_q <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_pix || load_frame) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_data.last) begin
							fire_tally_q  <= '0;
							color_tally_q <= '0;
							pixel_tally_q <= '0;
							state_q       <= ST_MUL;
						end else begin
							fire_tally_q  <= fcnt;
							color_tally_q <= ccnt;
							pixel_tally_q <= pcnt;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == fcpm_pkg::STEP_W'(fcpm_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						level_q <= lvl;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (pop && q_data.last) begin
			fcnt_q  <= fcnt;
			ccnt_q  <= ccnt;
			pcnt_q  <= pcnt;
			mask_q  <= fire;
			color_q <= q_data.color;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {5'b0, area_q, 17'b0} == '0 ? '0 : {22'b0, area_q} * {17'b0, pcnt_q};
		end
		if (state_q == ST_CMP) begin
			enough_q <= enough;
			num_q    <= num;
			divr_q   <= {1'b0, rate_q} + 1'b1;
			rem_q    <= '0;
		end
		if (state_q == ST_DIV) begin
			// restoring division, one quotient bit per cycle
			rem_q <= rem_ge ? fcpm_pkg::DIVR_W'(rem_sh - {1'b0, divr_q})
			                : rem_sh[fcpm_pkg::DIVR_W-1:0];
			num_q <= {num_q[fcpm_pkg::NUM_W-2:0], rem_ge};
		end
		if (load_pix) begin
			fire_mask        <= fire;
			by_color_rule    <= q_data.color;
			frame_done       <= 1'b0;
			fire_count       <= '0;
			color_rule_count <= '0;
			color_enough     <= 1'b0;
			history_level    <= '0;
		end else if (load_frame) begin
			fire_mask        <= mask_q;
			by_color_rule    <= color_q;
			frame_done       <= 1'b1;
			fire_count       <= fcnt_q;
			color_rule_count <= ccnt_q;
			color_enough     <= enough_q;
			history_level    <= lvl;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= fcpm_pkg::Q16_ONE)
		else $error("history level above one");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue read during frame-end work");
	a_idle_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_done) |-> (fire_count == '0 && color_rule_count == '0
		&& !color_enough && history_level == '0))
		else $error("frame fields set on a pixel inside the frame");
	a_color_le_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (color_rule_count <= fire_count))
		else $error("color count above fire count");
	a_level_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> (level_q == $past(level_q)))
		else $error("level changed outside frame end");

endmodule

>>> sv/fire_color_pixel_mask.sv
`timescale 1ns / 1ps
// out_valid rises once a pixel transaction has passed a queue slot, then the output register
// throughput: 1 pixel per cycle inside a frame while out_ready is high; the last pixel
// of a frame holds the accumulator for product, compare, a 25-step level division and output
// a 4-entry queue after the classifier absorbs part of that, then in_ready drops
// reset: asynchronous, active low; state and config registers reset, datapath not, level at 1.0
module fire_color_pixel_mask (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [fcpm_pkg::PIX_W-1:0]          red,
	input  logic [fcpm_pkg::PIX_W-1:0]          green,
	input  logic [fcpm_pkg::PIX_W-1:0]          blue,
	input  logic                                frame_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                fire_mask,
	output logic                                by_color_rule,
	output logic                                frame_done,
	output logic [fcpm_pkg::CNT_W-1:0]          fire_count,
	output logic [fcpm_pkg::CNT_W-1:0]          color_rule_count,
	output logic                                color_enough,
	output logic [fcpm_pkg::LEVEL_W-1:0]        history_level,
	input  logic                                cfg_we,
	input  logic [fcpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcpm_pkg::CFG_W-1:0]          cfg_data
);

	fcpm_pkg::class_t  cls;
	fcpm_pkg::class_t  q_data;
	fcpm_pkg::cfg_wr_t cfg;
	logic              q_full;
	logic              q_not_empty;
	logic              pop;
	logic              push;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		cfg.we    = cfg_we;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	fcpm_front u_front (
		.red       (red),
		.green     (green),
		.blue      (blue),
		.frame_end (frame_end),
		.cls       (cls)
	);

	fcpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	fcpm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.q_not_empty      (q_not_empty),
		.q_data           (q_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.fire_mask        (fire_mask),
		.by_color_rule    (by_color_rule),
		.frame_done       (frame_done),
		.fire_count       (fire_count),
		.color_rule_count (color_rule_count),
		.color_enough     (color_enough),
		.history_level    (history_level)
	);

endmodule
